// ----- design/cap_touch_averaged_edge_detector_top_defines.svh -----
// Assertion macros used by the touch detector top level.
`ifndef CAP_TOUCH_AVERAGED_EDGE_DETECTOR_TOP_DEFINES_SVH
`define CAP_TOUCH_AVERAGED_EDGE_DETECTOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTAED_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ctaed assertion failed");
`define CTAED_ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("ctaed forbidden condition seen");
`else
`define CTAED_ASSERT(name, clk, rst_n, prop)
`define CTAED_ASSERT_NEVER(name, clk, rst_n, prop)
`endif
`endif

// ----- design/ctaed_pkg.sv -----
// Shared types and constants of the capacitive touch detector.
`default_nettype none
package ctaed_pkg;
  localparam int CNT_W = 8;
  localparam int THR_W = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THRESHOLD = 1'b1;

  localparam logic [CNT_W-1:0] CNT_RESET = 8'd30;
  localparam logic [THR_W-1:0] THR_RESET = 10'd1000;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } ctaed_cmd_t;

  typedef struct packed {
    logic grp_end;
    logic calib;
    logic out_full;
  } ctaed_stat_t;
endpackage
`default_nettype wire

// ----- design/cap_touch_averaged_edge_detector_top.sv -----
// Top level of the capacitive touch detector with baseline subtraction.
//
//  Channel  | Signals                                  | Content
//  ---------+------------------------------------------+--------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata               | one converter sample per item
//  m_axis   | m_axis_tvalid/tready/tdata               | one result per measuring group
//  cfg      | cfg_valid_i/cfg_ready_o/index/data       | sample_count, touch_threshold
//
// A sample that does not close a group only updates the running sum.
// A sample that closes a measuring group after calibration starts
// the bit-serial restoring divider, one quotient bit per cycle.
// The result register frees the input while a result waits; a new result waits
// in the controller until the previous one is taken.
// Reset is asynchronous and active low and restarts calibration.
`default_nettype none
`include "cap_touch_averaged_edge_detector_top_defines.svh"
module cap_touch_averaged_edge_detector_top #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // adc_sample
  input  wire [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // touch_event, touched, average_level
  output logic [((SAMPLE_BITS+2+7)/8)*8-1:0]   m_axis_tdata,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [ctaed_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [ctaed_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ctaed_pkg::*;

  localparam int OUT_W = ((SAMPLE_BITS + 2 + 7) / 8) * 8;

  ctaed_cmd_t  cmd;
  ctaed_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ctaed_ctrl #(
    .STEPS (SAMPLE_BITS + 8)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ctaed_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_W       (OUT_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  `CTAED_ASSERT_NEVER(a_load_into_full, clk_i, rst_ni, cmd.load_out && stat.out_full)
  `CTAED_ASSERT_NEVER(a_accept_while_div, clk_i, rst_ni, s_axis_tready && cmd.div_step)
  `CTAED_ASSERT(a_valid_from_load, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(cmd.load_out))
endmodule
`default_nettype wire

// ----- design/ctaed_ctrl.sv -----
// Controller state machine: sample intake, divider sequencing, result hand-off.
`default_nettype none
module ctaed_ctrl #(
  parameter int STEPS = 18
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  ctaed_pkg::ctaed_stat_t  stat_i,
  output ctaed_pkg::ctaed_cmd_t   cmd_o
);
  import ctaed_pkg::*;

  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.grp_end && !stat_i.calib) begin
          state_d = ST_DIV;
          step_d  = '0;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!stat_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end
endmodule
`default_nettype wire

// ----- design/ctaed_dp.sv -----
// Datapath: configuration, sums, baseline, bit-serial divider and result register.
`default_nettype none
module ctaed_dp #(
  parameter int SAMPLE_BITS = 10,
  parameter int OUT_W = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [ctaed_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [ctaed_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire [SAMPLE_BITS-1:0]            sample_i,
  input  ctaed_pkg::ctaed_cmd_t            cmd_i,
  output ctaed_pkg::ctaed_stat_t           stat_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [OUT_W-1:0]                 out_data_o
);
  import ctaed_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 8;

  logic [CNT_W-1:0]   count_q;
  logic [THR_W-1:0]   thr_q;
  logic               calib_q;
  logic [CNT_W-1:0]   idx_q;
  logic [SUM_W-1:0]   run_q, base_q;
  logic [SUM_W-1:0]   quo_q;
  logic [CNT_W-1:0]   rem_q, div_q;
  logic               held_q;
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_data_q;

  logic [CNT_W-1:0]   n_eff, idx_inc;
  logic [SUM_W-1:0]   sum_new;
  logic               grp_end;
  logic [CNT_W:0]     trial, trial_sub;
  logic               q_bit;
  logic               over;

  assign n_eff   = (count_q == '0) ? CNT_W'(1) : count_q;
  assign idx_inc = idx_q + 1'b1;
  assign grp_end = idx_inc >= n_eff;
  assign sum_new = run_q + SUM_W'(sample_i);

  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign q_bit     = trial >= {1'b0, div_q};

  assign over = quo_q > {{(SUM_W-THR_W){1'b0}}, thr_q};

  assign stat_o.grp_end  = grp_end;
  assign stat_o.calib    = calib_q;
  assign stat_o.out_full = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
      thr_q   <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_COUNT:    count_q <= cfg_data_i[CNT_W-1:0];
        CFG_TOUCH_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= 1'b1;
      idx_q   <= '0;
      run_q   <= '0;
      base_q  <= '0;
    end else if (cmd_i.accept) begin
      if (grp_end) begin
        idx_q <= '0;
        run_q <= '0;
        if (calib_q) begin
          base_q  <= sum_new;
          calib_q <= 1'b0;
        end
      end else begin
        idx_q <= idx_inc;
        run_q <= sum_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && grp_end && !calib_q) begin
      quo_q <= (sum_new > base_q) ? (sum_new - base_q) : '0;
      rem_q <= '0;
      div_q <= n_eff;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], q_bit};
      rem_q <= q_bit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      held_q      <= over;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= OUT_W'({quo_q[SAMPLE_BITS-1:0], over, over & ~held_q});
    end
  end
endmodule
`default_nettype wire
